FILE: rtl/mbet_pkg.sv
`timescale 1ns / 1ps
package mbet_pkg;

  // Coordinate format: signed Q4.28
  localparam int CoordWidth = 32;
  localparam int FracBits   = 28;
  localparam int CountWidth = 32;
  localparam int IterWidth  = 16;

  // Exact products and the wider sums built from them
  localparam int ProdWidth  = 2 * CoordWidth;
  localparam int SumWidth   = ProdWidth + 2;

  // 4.0 at 2*FracBits fraction bits
  localparam int ThreshShift = 2 * FracBits + 2;
  localparam logic [SumWidth-1:0] EscThresh =
    {{(SumWidth-1){1'b0}}, 1'b1} << ThreshShift;

  localparam logic [IterWidth-1:0] MaxIterReset = IterWidth'(1000);

  typedef enum logic [1:0] {
    StIdle,
    StMul,
    StTest
  } ctrl_state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;    // take a new point, z = c, clear the step count
    logic mul_en;  // register the three products of z
    logic step;    // write the updated z, advance the step count
    logic finish;  // write the result and update the running count
  } mbet_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic escape;  // |z|^2 > 4 after at least one update
    logic limit;   // step count has reached max_iter
  } mbet_status_t;

endpackage

FILE: rtl/mbet_datapath.sv
`timescale 1ns / 1ps
module mbet_datapath import mbet_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  mbet_cmd_t                    cmd_i,
  output mbet_status_t                 status_o,
  input  logic                         cfg_we_i,
  input  logic [IterWidth-1:0]         cfg_data_i,
  input  logic signed [CoordWidth-1:0] point_re_i,
  input  logic signed [CoordWidth-1:0] point_im_i,
  output logic                         escaped_o,
  output logic [CountWidth-1:0]        outside_total_o
);

  logic [IterWidth-1:0]         max_iter_q;
  logic signed [CoordWidth-1:0] c_re_q, c_im_q;
  logic signed [CoordWidth-1:0] z_re_q, z_re_d;
  logic signed [CoordWidth-1:0] z_im_q, z_im_d;
  logic signed [ProdWidth-1:0]  rr_q, rr_d;
  logic signed [ProdWidth-1:0]  ii_q, ii_d;
  logic signed [ProdWidth-1:0]  ri_q, ri_d;
  logic [IterWidth-1:0]         iter_q, iter_d;
  logic [CountWidth-1:0]        count_q, count_d;
  logic                         escaped_q;
  logic [SumWidth-1:0]          mag_sum;
  logic signed [SumWidth-1:0]   re_diff, re_sum, im_sum;

  // Clamp a wide signed value to the coordinate range
  function automatic logic signed [CoordWidth-1:0] sat_coord(
    input logic signed [SumWidth-1:0] v
  );
    logic [SumWidth-CoordWidth:0] top;
    top = v[SumWidth-1:CoordWidth-1];
    if ((&top) || !(|top)) begin
      return v[CoordWidth-1:0];
    end else if (v[SumWidth-1]) begin
      return {1'b1, {(CoordWidth-1){1'b0}}};
    end else begin
      return {1'b0, {(CoordWidth-1){1'b1}}};
    end
  endfunction

  // Iteration limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_iter_q <= MaxIterReset;
    end else if (cfg_we_i) begin
      max_iter_q <= cfg_data_i;
    end
  end

  // Products of the current z
  assign rr_d = z_re_q * z_re_q;
  assign ii_d = z_im_q * z_im_q;
  assign ri_d = z_re_q * z_im_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      rr_q <= rr_d;
      ii_q <= ii_d;
      ri_q <= ri_d;
    end
  end

  // Escape test on the squares of the updated z; both squares are nonnegative
  assign mag_sum = SumWidth'(unsigned'(rr_q)) + SumWidth'(unsigned'(ii_q));

  // Next z: real part (zr^2 - zi^2) >> F + cr, imaginary part 2*zr*zi >> F + ci
  assign re_diff = SumWidth'(rr_q) - SumWidth'(ii_q);
  assign re_sum  = (re_diff >>> FracBits) + SumWidth'(c_re_q);
  assign im_sum  = (SumWidth'(ri_q) >>> (FracBits - 1)) + SumWidth'(c_im_q);

  always_comb begin
    z_re_d = z_re_q;
    z_im_d = z_im_q;
    iter_d = iter_q;
    if (cmd_i.load) begin
      z_re_d = point_re_i;
      z_im_d = point_im_i;
      iter_d = '0;
    end else if (cmd_i.step) begin
      z_re_d = sat_coord(re_sum);
      z_im_d = sat_coord(im_sum);
      iter_d = iter_q + IterWidth'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    z_re_q <= z_re_d;
    z_im_q <= z_im_d;
    if (cmd_i.load) begin
      c_re_q <= point_re_i;
      c_im_q <= point_im_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iter_q <= '0;
    end else begin
      iter_q <= iter_d;
    end
  end

  assign status_o.escape = (iter_q != '0) && (mag_sum > EscThresh);
  assign status_o.limit  = (iter_q == max_iter_q);

  // Running count of escaped points, held at its maximum once full
  always_comb begin
    count_d = count_q;
    if (cmd_i.finish && status_o.escape && (count_q != '1)) begin
      count_d = count_q + CountWidth'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      escaped_q <= status_o.escape;
    end
  end

  assign escaped_o       = escaped_q;
  assign outside_total_o = count_q;

endmodule

FILE: rtl/mbet_ctrl.sv
`timescale 1ns / 1ps
module mbet_ctrl import mbet_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  input  mbet_status_t status_i,
  output mbet_cmd_t    cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        done;
  logic        slot_free;

  // A point is done when it escaped or used up its updates
  assign done      = status_i.escape || status_i.limit;
  assign slot_free = !out_valid_q || out_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          state_d = StMul;
        end
      end
      StMul: begin
        state_d = StTest;
      end
      StTest: begin
        if (!done) begin
          state_d = StMul;
        end else if (slot_free) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      StMul: begin
        cmd_o.mul_en = 1'b1;
      end
      StTest: begin
        cmd_o.step   = !done;
        cmd_o.finish = done && slot_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  // Result valid: set on finish, drop on transfer
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: rtl/mandelbrot_escape_test.sv
`timescale 1ns / 1ps
// Escape-time test of one point c of the complex plane, given as signed Q4.28
// coordinates. Starting from z = c, the block repeats z = z*z + c (saturating
// to the coordinate range) up to max_iter times and flags the point as escaped
// once |z|^2 exceeds 4.0; a saturating running count of escaped points is
// returned with each result. One point is worked on at a time. Each update
// passes through the set of three 32x32 multipliers and then the add,
// saturate and compare stage behind their product registers. The next point
// can be taken in the cycle after a result is registered; a result waiting at
// the output does not hold up work on the next point until that point's own
// result is ready. max_iter is to be written by the user through the
// configuration channel only while the block is idle; the block itself
// does not enforce this.
module mandelbrot_escape_test import mbet_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [IterWidth-1:0]         cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [CoordWidth-1:0] point_re_i,
  input  logic signed [CoordWidth-1:0] point_im_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         escaped_o,
  output logic [CountWidth-1:0]        outside_total_o
);

  mbet_cmd_t    cmd;
  mbet_status_t status;
  logic         cfg_we;

  // The limit register takes a write in any cycle
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  mbet_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  mbet_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .cfg_we_i        (cfg_we),
    .cfg_data_i      (cfg_data_i),
    .point_re_i      (point_re_i),
    .point_im_i      (point_im_i),
    .escaped_o       (escaped_o),
    .outside_total_o (outside_total_o)
  );

endmodule
